// File: rtl/etrle_pkg.sv
package etrle_pkg;

    // Field widths
    localparam int COLOR_BITS      = 16;
    localparam int PAL_ADDR_BITS   = 8;
    localparam int PALETTE_ENTRIES = 1 << PAL_ADDR_BITS;
    localparam int COORD_BITS      = 16;
    localparam int RUN_BITS        = 7;
    localparam int ERR_BITS        = 3;
    localparam int ACTION_BITS     = 2;
    localparam int CFG_IDX_BITS    = 1;

    // Action codes
    localparam logic [ACTION_BITS-1:0] ACT_LOAD    = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_RESTART = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_BYTE    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 1'd1;

    // Error codes
    localparam logic [ERR_BITS-1:0] ERR_NONE       = 3'd0;
    localparam logic [ERR_BITS-1:0] ERR_ZERO_RUN   = 3'd1;
    localparam logic [ERR_BITS-1:0] ERR_PAST_ROW   = 3'd2;
    localparam logic [ERR_BITS-1:0] ERR_TRUNCATED  = 3'd3;
    localparam logic [ERR_BITS-1:0] ERR_INCOMPLETE = 3'd4;
    localparam logic [ERR_BITS-1:0] ERR_TRAILING   = 3'd5;

    // Item held in the input register
    typedef struct packed {
        logic [ACTION_BITS-1:0] action;
        logic [7:0]             data_byte;
        logic                   last_byte;
    } item_t;

    // Region geometry
    typedef struct packed {
        logic [COORD_BITS-1:0] width;
        logic [COORD_BITS-1:0] height;
    } region_cfg_t;

endpackage

// File: rtl/etrle_sprite_region_decoder.sv
// Transparent run-length sprite region decoder.
// Input channel (s_*): one beat per palette load, region restart or
// encoded source byte. A load writes the palette at acceptance; a byte
// beat reads the palette at acceptance.
// Result channel (m_*): at most one beat per byte: an opaque pixel with
// its row, column and color, and/or the region_done beat carrying the
// error code on the byte marked last.
// Configuration channel (cfg_*): region width (index 0) and height
// (index 1), always ready; write only while the decoder is idle.
// Throughput: one beat per cycle on both sides when the receiver keeps
// m_ready high. A beat accepted sits in the input register while its
// palette color is read into the registered read port; its result is
// then loaded into the output register.
// A receiver stall holds the output register and backs up into the input
// register; s_ready drops only when both are full.
// Reset: decode position, sticky error and valid flags clear; width and
// height return to 1. Palette contents are undefined until loaded.
module etrle_sprite_region_decoder (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [etrle_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [etrle_pkg::COORD_BITS-1:0]       cfg_data,
    // input channel
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [etrle_pkg::ACTION_BITS-1:0]      s_action,
    input  logic [7:0]                             s_palette_index,
    input  logic [15:0]                            s_palette_color,
    input  logic [7:0]                             s_data_byte,
    input  logic                                   s_last_byte,
    // result channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_pixel_written,
    output logic [15:0]                            m_pixel_row,
    output logic [15:0]                            m_pixel_column,
    output logic [15:0]                            m_pixel_color,
    output logic                                   m_region_done,
    output logic [2:0]                             m_error_code
);

    etrle_pkg::region_cfg_t              cfg_reg, cfg_next;
    etrle_pkg::item_t                    item_reg, item_next;
    logic                                s1_valid_reg, s1_valid_next;
    logic                                dec_ready;
    logic                                accept;
    logic [etrle_pkg::COLOR_BITS-1:0]    rd_color;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                etrle_pkg::CFG_WIDTH:  cfg_next.width  = cfg_data;
                etrle_pkg::CFG_HEIGHT: cfg_next.height = cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    assign s_ready = !s1_valid_reg || dec_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        item_next     = item_reg;
        if (accept) begin
            s1_valid_next       = 1'b1;
            item_next.action    = s_action;
            item_next.data_byte = s_data_byte;
            item_next.last_byte = s_last_byte;
        end else if (dec_ready) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.width  <= 16'd1;
            cfg_reg.height <= 16'd1;
            s1_valid_reg   <= 1'b0;
        end else begin
            cfg_reg      <= cfg_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    // palette: written by load beats, read by byte beats at acceptance
    etrle_palette u_palette (
        .aclk    (aclk),
        .wr_en   (accept && s_action == etrle_pkg::ACT_LOAD),
        .wr_addr (s_palette_index),
        .wr_data (s_palette_color),
        .rd_en   (accept && s_action == etrle_pkg::ACT_BYTE),
        .rd_addr (s_data_byte),
        .rd_data (rd_color)
    );

    etrle_decode u_decode (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .in_valid        (s1_valid_reg),
        .in_item         (item_reg),
        .in_color        (rd_color),
        .in_ready        (dec_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_written (m_pixel_written),
        .m_pixel_row     (m_pixel_row),
        .m_pixel_column  (m_pixel_column),
        .m_pixel_color   (m_pixel_color),
        .m_region_done   (m_region_done),
        .m_error_code    (m_error_code)
    );

endmodule

// File: rtl/etrle_palette.sv
module etrle_palette (
    input  logic                                 aclk,
    input  logic                                 wr_en,
    input  logic [etrle_pkg::PAL_ADDR_BITS-1:0]  wr_addr,
    input  logic [etrle_pkg::COLOR_BITS-1:0]     wr_data,
    input  logic                                 rd_en,
    input  logic [etrle_pkg::PAL_ADDR_BITS-1:0]  rd_addr,
    output logic [etrle_pkg::COLOR_BITS-1:0]     rd_data
);

    logic [etrle_pkg::COLOR_BITS-1:0] mem [etrle_pkg::PALETTE_ENTRIES];
    logic [etrle_pkg::COLOR_BITS-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/etrle_decode.sv
module etrle_decode (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  etrle_pkg::region_cfg_t                cfg,
    input  logic                                  in_valid,
    input  etrle_pkg::item_t                      in_item,
    input  logic [etrle_pkg::COLOR_BITS-1:0]      in_color,
    output logic                                  in_ready,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_pixel_written,
    output logic [etrle_pkg::COORD_BITS-1:0]      m_pixel_row,
    output logic [etrle_pkg::COORD_BITS-1:0]      m_pixel_column,
    output logic [15:0]                           m_pixel_color,
    output logic                                  m_region_done,
    output logic [etrle_pkg::ERR_BITS-1:0]        m_error_code
);

    localparam int CB = etrle_pkg::COORD_BITS;

    // decode state
    logic [CB-1:0]                      row_reg, row_next;
    logic [CB-1:0]                      col_reg, col_next;
    logic [etrle_pkg::RUN_BITS-1:0]     lit_reg, lit_next;
    logic [etrle_pkg::ERR_BITS-1:0]     err_reg, err_next;

    // result register
    logic                               m_valid_reg, m_valid_next;
    logic                               pix_reg, pix_next;
    logic [CB-1:0]                      prow_reg, prow_next;
    logic [CB-1:0]                      pcol_reg, pcol_next;
    logic [15:0]                        pcolor_reg, pcolor_next;
    logic                               done_reg, done_next;
    logic [etrle_pkg::ERR_BITS-1:0]     code_reg, code_next;

    logic                               take;
    logic                               is_byte;
    logic                               pixel;
    logic [etrle_pkg::RUN_BITS-1:0]     run;
    logic [CB-1:0]                      room;
    logic [etrle_pkg::ERR_BITS-1:0]     final_err;

    assign in_ready = !m_valid_reg || m_ready;
    assign take     = in_valid && in_ready;
    assign is_byte  = (in_item.action == etrle_pkg::ACT_BYTE);
    assign run      = in_item.data_byte[etrle_pkg::RUN_BITS-1:0];
    assign room     = (col_reg < cfg.width) ? (cfg.width - col_reg) : '0;

    // byte decision and state update
    always_comb begin
        row_next  = row_reg;
        col_next  = col_reg;
        lit_next  = lit_reg;
        err_next  = err_reg;
        pixel     = 1'b0;
        final_err = etrle_pkg::ERR_NONE;
        if (take && is_byte) begin
            if (err_reg == etrle_pkg::ERR_NONE) begin
                if (cfg.width == '0 || cfg.height == '0) begin
                    err_next = etrle_pkg::ERR_INCOMPLETE;
                end else if (row_reg >= cfg.height) begin
                    err_next = etrle_pkg::ERR_TRAILING;
                end else if (lit_reg != '0) begin
                    pixel    = 1'b1;
                    col_next = col_reg + 1'b1;
                    lit_next = lit_reg - 1'b1;
                end else if (in_item.data_byte == 8'd0) begin
                    if (col_reg != cfg.width) begin
                        err_next = etrle_pkg::ERR_INCOMPLETE;
                    end else begin
                        row_next = row_reg + 1'b1;
                        col_next = '0;
                    end
                end else if (run == '0) begin
                    err_next = etrle_pkg::ERR_ZERO_RUN;
                end else if ({{(CB-etrle_pkg::RUN_BITS){1'b0}}, run} > room) begin
                    err_next = etrle_pkg::ERR_PAST_ROW;
                end else if (in_item.data_byte[7]) begin
                    col_next = col_reg + {{(CB-etrle_pkg::RUN_BITS){1'b0}}, run};
                end else begin
                    lit_next = run;
                end
            end
            // end of stream report, then back to region start
            if (in_item.last_byte) begin
                final_err = err_next;
                if (err_next == etrle_pkg::ERR_NONE) begin
                    if (lit_next != '0) begin
                        final_err = etrle_pkg::ERR_TRUNCATED;
                    end else if (row_next < cfg.height) begin
                        final_err = etrle_pkg::ERR_INCOMPLETE;
                    end
                end
                row_next = '0;
                col_next = '0;
                lit_next = '0;
                err_next = etrle_pkg::ERR_NONE;
            end
        end else if (take && in_item.action == etrle_pkg::ACT_RESTART) begin
            row_next = '0;
            col_next = '0;
            lit_next = '0;
            err_next = etrle_pkg::ERR_NONE;
        end
    end

    // result register load
    always_comb begin
        m_valid_next = m_valid_reg;
        pix_next     = pix_reg;
        prow_next    = prow_reg;
        pcol_next    = pcol_reg;
        pcolor_next  = pcolor_reg;
        done_next    = done_reg;
        code_next    = code_reg;
        if (in_ready) begin
            m_valid_next = take && is_byte && (pixel || in_item.last_byte);
            pix_next     = pixel;
            prow_next    = pixel ? row_reg : '0;
            pcol_next    = pixel ? col_reg : '0;
            pcolor_next  = pixel ? in_color[15:0] : '0;
            done_next    = in_item.last_byte;
            code_next    = final_err;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg     <= '0;
            col_reg     <= '0;
            lit_reg     <= '0;
            err_reg     <= etrle_pkg::ERR_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            row_reg     <= row_next;
            col_reg     <= col_next;
            lit_reg     <= lit_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pix_reg    <= pix_next;
        prow_reg   <= prow_next;
        pcol_reg   <= pcol_next;
        pcolor_reg <= pcolor_next;
        done_reg   <= done_next;
        code_reg   <= code_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_pixel_written = pix_reg;
    assign m_pixel_row     = prow_reg;
    assign m_pixel_column  = pcol_reg;
    assign m_pixel_color   = pcolor_reg;
    assign m_region_done   = done_reg;
    assign m_error_code    = code_reg;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

    // Stream codes not named by the package
    localparam logic [etrle_pkg::ACTION_BITS-1:0] ACT_UNUSED = 2'd3;
    localparam logic [7:0]             ROW_END    = 8'h00;
    localparam logic [7:0]             SKIP_FLAG  = 8'h80;
    localparam logic [7:0]             RUN_MASK   = 8'h7F;
    localparam int                     RANDOM_BEATS = 1500;
    localparam int                     LONG_STALL   = 400;

    typedef struct packed {
        logic [etrle_pkg::ACTION_BITS-1:0] action;
        logic [7:0]             pidx;
        logic [15:0]            pcolor;
        logic [7:0]             dbyte;
        logic                   last;
    } src_beat_t;

    typedef struct packed {
        logic        written;
        logic [15:0] row;
        logic [15:0] column;
        logic [15:0] color;
        logic        done;
        logic [2:0]  err;
    } pix_beat_t;

    typedef enum int {
        DAMAGE_NONE, DAMAGE_ZERO_RUN, DAMAGE_LONG_RUN, DAMAGE_CUT,
        DAMAGE_DROP, DAMAGE_TRAILING, DAMAGE_FLIP
    } damage_t;

    logic                     aclk    = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [etrle_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [etrle_pkg::COORD_BITS-1:0]    cfg_data  = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [etrle_pkg::ACTION_BITS-1:0]   s_action = '0;
    logic [7:0]               s_palette_index = '0;
    logic [15:0]              s_palette_color = '0;
    logic [7:0]               s_data_byte = '0;
    logic                     s_last_byte = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_pixel_written;
    logic [15:0]              m_pixel_row;
    logic [15:0]              m_pixel_column;
    logic [15:0]              m_pixel_color;
    logic                     m_region_done;
    logic [2:0]               m_error_code;

    etrle_sprite_region_decoder dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_palette_index (s_palette_index),
        .s_palette_color (s_palette_color),
        .s_data_byte     (s_data_byte),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_written (m_pixel_written),
        .m_pixel_row     (m_pixel_row),
        .m_pixel_column  (m_pixel_column),
        .m_pixel_color   (m_pixel_color),
        .m_region_done   (m_region_done),
        .m_error_code    (m_error_code)
    );

    always #1 aclk = ~aclk;

    // Shadow copy of the decoder state
    logic [15:0]  shadow_palette [0:255];
    int unsigned  shadow_width  = 1;
    int unsigned  shadow_height = 1;
    int unsigned  cur_row, cur_col, lit_left;
    logic [2:0]   sticky_err = etrle_pkg::ERR_NONE;

    src_beat_t    byte_stream [$];
    pix_beat_t    owed_beats  [$];

    int beats_queued = 0, beats_taken = 0, real_beats = 0;
    int results_seen = 0, mismatches = 0, settings_used = 1;
    int done_by_err [0:7];
    int burst_left = 1, gap_left = 0;
    int hold_asks = 0, hold_seen = 0, hold_left = 0;
    int rx_cycle = 0, rx_mode = 0;

    task automatic restart_shadow();
        cur_row    = 0;
        cur_col    = 0;
        lit_left   = 0;
        sticky_err = etrle_pkg::ERR_NONE;
    endtask

    // Advance the shadow decoder by one accepted beat, queue any owed result
    task automatic decode_item(input src_beat_t b);
        pix_beat_t   r;
        int unsigned run, room;
        r = '0;
        if (b.action == etrle_pkg::ACT_LOAD) begin
            shadow_palette[b.pidx] = b.pcolor;
        end else if (b.action == etrle_pkg::ACT_RESTART) begin
            restart_shadow();
        end else if (b.action == etrle_pkg::ACT_BYTE) begin
            if (sticky_err == etrle_pkg::ERR_NONE) begin
                if (shadow_width == 0 || shadow_height == 0) begin
                    sticky_err = etrle_pkg::ERR_INCOMPLETE;
                end else if (cur_row >= shadow_height) begin
                    sticky_err = etrle_pkg::ERR_TRAILING;
                end else if (lit_left > 0) begin
                    r.written = 1'b1;
                    r.row     = cur_row[15:0];
                    r.column  = cur_col[15:0];
                    r.color   = shadow_palette[b.dbyte];
                    cur_col   = (cur_col + 1) & 32'hFFFF;
                    lit_left--;
                end else if (b.dbyte == ROW_END) begin
                    if (cur_col != shadow_width) begin
                        sticky_err = etrle_pkg::ERR_INCOMPLETE;
                    end else begin
                        cur_row++;
                        cur_col = 0;
                    end
                end else begin
                    run  = 32'(b.dbyte & RUN_MASK);
                    room = (cur_col < shadow_width) ? shadow_width - cur_col : 0;
                    if (run == 0)
                        sticky_err = etrle_pkg::ERR_ZERO_RUN;
                    else if (run > room)
                        sticky_err = etrle_pkg::ERR_PAST_ROW;
                    else if ((b.dbyte & SKIP_FLAG) != 0)
                        cur_col += run;
                    else
                        lit_left = run;
                end
            end
            if (b.last || r.written) begin
                if (b.last) begin
                    r.done = 1'b1;
                    r.err  = sticky_err;
                    if (sticky_err == etrle_pkg::ERR_NONE) begin
                        if (lit_left > 0)
                            r.err = etrle_pkg::ERR_TRUNCATED;
                        else if (cur_row < shadow_height)
                            r.err = etrle_pkg::ERR_INCOMPLETE;
                    end
                    restart_shadow();
                end
                owed_beats.push_back(r);
            end
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %0s at result %0d: expected %0h, got %0h",
                     what, results_seen, want, got);
    endtask

    task automatic push_beat(input logic [etrle_pkg::ACTION_BITS-1:0] act,
                             input logic [7:0] idx,
                             input logic [15:0] color, input logic [7:0] b,
                             input logic last);
        byte_stream.push_back({act, idx, color, b, last});
        beats_queued++;
        if (act != ACT_UNUSED)
            real_beats++;
    endtask

    // Beat whose unused fields carry random values
    task automatic push_ctrl(input logic [etrle_pkg::ACTION_BITS-1:0] act);
        push_beat(act, 8'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic push_src_byte(input logic [7:0] b, input logic last);
        push_beat(etrle_pkg::ACT_BYTE, 8'($urandom), 16'($urandom), b, last);
    endtask

    // Encode one region with random skips and literals, optionally damaged
    task automatic gen_region(input int unsigned w, input int unsigned h,
                              input int unsigned nrows, input bit may_damage);
        logic [7:0]  raw [$];
        logic [7:0]  shaped [$];
        int unsigned col, run, room, pos;
        damage_t     damage;
        for (int r = 0; r < nrows; r++) begin
            col = 0;
            while (col < w) begin
                room = w - col;
                if (room > 127) begin
                    // wide rows: mostly long skips so the row stays short
                    if ($urandom_range(0, 7) == 0) begin
                        run = $urandom_range(1, 3);
                        raw.push_back(8'(run));
                        repeat (run) raw.push_back(8'($urandom_range(0, 255)));
                    end else begin
                        run = $urandom_range(96, 127);
                        raw.push_back(SKIP_FLAG | 8'(run));
                    end
                end else begin
                    run = $urandom_range(1, room);
                    if ($urandom_range(0, 1) == 0) begin
                        raw.push_back(SKIP_FLAG | 8'(run));
                    end else begin
                        raw.push_back(8'(run));
                        repeat (run) raw.push_back(8'($urandom_range(0, 255)));
                    end
                end
                col += run;
            end
            raw.push_back(ROW_END);
        end

        damage = DAMAGE_NONE;
        if (may_damage && $urandom_range(0, 3) == 0)
            damage = damage_t'($urandom_range(1, 6));
        pos = $urandom_range(0, raw.size() - 1);
        for (int i = 0; i < raw.size(); i++) begin
            if (i == pos && damage == DAMAGE_ZERO_RUN)
                shaped.push_back(SKIP_FLAG);
            if (i == pos && damage == DAMAGE_LONG_RUN)
                shaped.push_back($urandom_range(0, 1) ? 8'hFF : 8'h7F);
            if (i == pos && damage == DAMAGE_FLIP)
                shaped.push_back(8'($urandom_range(0, 255)));
            else if (!(i == pos && damage == DAMAGE_DROP))
                shaped.push_back(raw[i]);
            if (i == pos && damage == DAMAGE_CUT)
                break;
        end
        if (damage == DAMAGE_TRAILING)
            repeat ($urandom_range(1, 3)) shaped.push_back(8'($urandom_range(0, 255)));
        if (shaped.size() == 0)
            shaped.push_back(8'($urandom_range(0, 255)));

        // emit, with loads, restarts and ignored beats sprinkled in
        if ($urandom_range(0, 2) == 0)
            push_ctrl(etrle_pkg::ACT_RESTART);
        for (int i = 0; i < shaped.size(); i++) begin
            if ($urandom_range(0, 23) == 0)
                push_ctrl(etrle_pkg::ACT_LOAD);
            if ($urandom_range(0, 39) == 0)
                push_ctrl(ACT_UNUSED);
            if ($urandom_range(0, 79) == 0)
                push_ctrl(etrle_pkg::ACT_RESTART);
            push_src_byte(shaped[i], i == shaped.size() - 1);
        end
    endtask

    task automatic write_reg(input logic [etrle_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == etrle_pkg::CFG_WIDTH)
            shadow_width = 32'(val);
        else
            shadow_height = 32'(val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // All beats taken, all results back, then let no-result beats drain
    task automatic wait_idle();
        do @(posedge aclk); while (beats_taken != beats_queued || owed_beats.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    // Source driver: bursts with random gaps
    always @(posedge aclk) begin : drive_src
        src_beat_t nxt;
        logic      offer;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                decode_item({s_action, s_palette_index, s_palette_color,
                             s_data_byte, s_last_byte});
                beats_taken++;
            end
            offer = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (byte_stream.size() > 0) begin
                nxt             = byte_stream.pop_front();
                s_action        <= nxt.action;
                s_palette_index <= nxt.pidx;
                s_palette_color <= nxt.pcolor;
                s_data_byte     <= nxt.dbyte;
                s_last_byte     <= nxt.last;
                offer           = 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end else begin
                    burst_left--;
                end
            end
            s_valid <= offer;
        end
    end

    // Result receiver: shifting stall patterns plus requested long holds
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            rx_cycle++;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_seen != hold_asks) begin
                hold_seen = hold_asks;
                hold_left = LONG_STALL;
                m_ready <= 1'b0;
            end else begin
                if (rx_cycle % 48 == 0)
                    rx_mode = $urandom_range(0, 3);
                case (rx_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (rx_cycle % 4 != 3);
                endcase
            end
        end
    end

    // Result checker
    always @(posedge aclk) begin : check_pix
        pix_beat_t want, got;
        if (aresetn && m_valid && m_ready) begin
            got = {m_pixel_written, m_pixel_row, m_pixel_column, m_pixel_color,
                   m_region_done, m_error_code};
            results_seen++;
            if (owed_beats.size() == 0) begin
                flag_mismatch("unexpected result beat", 32'd0, 32'd1);
            end else begin
                want = owed_beats.pop_front();
                if (got.written !== want.written)
                    flag_mismatch("pixel_written", 32'(want.written), 32'(got.written));
                if (got.row !== want.row)
                    flag_mismatch("pixel_row", 32'(want.row), 32'(got.row));
                if (got.column !== want.column)
                    flag_mismatch("pixel_column", 32'(want.column), 32'(got.column));
                if (got.color !== want.color)
                    flag_mismatch("pixel_color", 32'(want.color), 32'(got.color));
                if (got.done !== want.done)
                    flag_mismatch("region_done", 32'(want.done), 32'(got.done));
                if (got.err !== want.err)
                    flag_mismatch("error_code", 32'(want.err), 32'(got.err));
                if (want.done)
                    done_by_err[want.err]++;
            end
        end
    end

    initial begin
        #400000;
        $display("etrle_sprite_region_decoder verification failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned w, h, nrows;
        int          ph, goal, stop_at, guard;
        foreach (done_by_err[i]) done_by_err[i] = 0;
        restart_shadow();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill the whole palette so no literal ever reads an unwritten entry
        for (int i = 0; i < 256; i++)
            push_beat(etrle_pkg::ACT_LOAD, 8'(i), 16'($urandom), 8'($urandom),
                      1'($urandom));

        // Directed region cases at the reset geometry of 1 x 1
        push_beat(etrle_pkg::ACT_LOAD, 8'd0, 16'h0000, 8'd0, 1'b0);
        push_beat(etrle_pkg::ACT_LOAD, 8'd255, 16'hFFFF, 8'hFF, 1'b1);
        push_src_byte(8'h01, 1'b0);
        push_src_byte(8'hFF, 1'b0);                // literal reads top entry
        push_src_byte(ROW_END, 1'b1);              // clean region
        push_src_byte(8'h81, 1'b0);
        push_src_byte(ROW_END, 1'b1);              // clean skip-only region
        push_src_byte(SKIP_FLAG, 1'b1);            // zero-length run
        push_src_byte(8'h02, 1'b1);                // run past row end
        push_src_byte(8'h01, 1'b1);                // literal owed at end
        push_src_byte(8'h01, 1'b0);
        push_src_byte(ROW_END, 1'b1);              // last byte carries a pixel, row open
        push_src_byte(ROW_END, 1'b1);              // row ended early
        push_src_byte(8'h81, 1'b0);
        push_src_byte(ROW_END, 1'b0);
        push_src_byte(8'h81, 1'b1);                // byte after final row
        push_src_byte(SKIP_FLAG, 1'b0);
        push_beat(etrle_pkg::ACT_RESTART, 8'hFF, 16'hFFFF, 8'hFF, 1'b1);  // clears the error
        push_src_byte(8'h81, 1'b0);
        push_src_byte(ROW_END, 1'b1);
        push_beat(ACT_UNUSED, 8'hFF, 16'hFFFF, ROW_END, 1'b1);
        wait_idle();

        // Random regions over a series of geometries, extremes first
        goal = real_beats + RANDOM_BEATS;
        ph   = 0;
        while (real_beats < goal) begin
            case (ph)
                0: begin w = 65535; h = 1; end
                2: begin w = $urandom_range(1, 9); h = 65535; end
                3: begin w = 0; h = $urandom_range(1, 4); end
                4: begin w = $urandom_range(1, 8); h = 0; end
                5: begin w = 1; h = 1; end
                default: begin w = $urandom_range(1, 20); h = $urandom_range(1, 5); end
            endcase
            write_reg(etrle_pkg::CFG_WIDTH, 16'(w));
            write_reg(etrle_pkg::CFG_HEIGHT, 16'(h));
            settings_used++;
            if (ph == 1 || ph == 8)
                hold_asks++;
            stop_at = real_beats + ((ph == 0) ? 1 : 150);
            while (real_beats < stop_at) begin
                if (h == 0 || h > 6)
                    nrows = $urandom_range(1, 3);
                else if ($urandom_range(0, 4) == 0)
                    nrows = $urandom_range(1, h);
                else
                    nrows = h;
                gen_region(w, h, nrows, w <= 1000);
            end
            wait_idle();
            ph++;
        end

        // Drain with a bound
        guard = 0;
        while ((beats_taken != beats_queued || owed_beats.size() != 0) && guard < 5000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (12) @(posedge aclk);
        if (owed_beats.size() != 0)
            flag_mismatch("results never delivered", 32'd0, 32'(owed_beats.size()));

        $display("covered %0d source beats over %0d region geometries, %0d results checked",
                 beats_taken, settings_used, results_seen);
        $display("region ends: ok %0d, zero run %0d, past row %0d, truncated %0d, %0s%0d, %0s%0d",
                 done_by_err[etrle_pkg::ERR_NONE], done_by_err[etrle_pkg::ERR_ZERO_RUN],
                 done_by_err[etrle_pkg::ERR_PAST_ROW], done_by_err[etrle_pkg::ERR_TRUNCATED],
                 "incomplete ", done_by_err[etrle_pkg::ERR_INCOMPLETE],
                 "trailing ", done_by_err[etrle_pkg::ERR_TRAILING]);
        if (mismatches == 0) begin
            $display("etrle_sprite_region_decoder verification clean");
        end else begin
            $display("etrle_sprite_region_decoder verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/etrle_pkg.sv
rtl/etrle_palette.sv
rtl/etrle_decode.sv
rtl/etrle_sprite_region_decoder.sv
sim/testbench.sv
